// ===== sv/cop_pkg.sv =====
package cop_pkg;

	// Saturation limits of the frame and persistence counters
	localparam int POINT_COUNT_MAX = 65535;
	localparam int PERSIST_MAX     = 255;
	localparam int COUNT_W         = $clog2(POINT_COUNT_MAX + 1);
	localparam int PERSIST_W       = $clog2(PERSIST_MAX + 1);

	localparam int HEIGHT_BAND_MM  = 1500;

	localparam int LEN_W       = 15;
	localparam int TAN_W       = 16;
	localparam int TRIG_W      = 16;
	localparam int PCFG_W      = 8;
	localparam int COORD_W     = 16;
	localparam int HITS_W      = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [LEN_W-1:0]  HALF_WIDTH_RST     = 15'd1000;
	localparam logic [LEN_W-1:0]  SLOWDOWN_LEN_RST   = 15'd6000;
	localparam logic [LEN_W-1:0]  AVOID_LEN_RST      = 15'd3500;
	localparam logic [LEN_W-1:0]  SENSOR_HEIGHT_RST  = 15'd1200;
	localparam logic [TAN_W-1:0]  ENVELOPE_TAN_RST   = 16'd256;
	localparam logic [TRIG_W-1:0] POINT_TRIGGER_RST  = 16'd10;
	localparam logic [PCFG_W-1:0] LIDAR_PERSIST_RST  = 8'd2;
	localparam logic [PCFG_W-1:0] CAMERA_PERSIST_RST = 8'd5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HALF_WIDTH     = 3'd0,
		CFG_SLOWDOWN_LEN   = 3'd1,
		CFG_AVOID_LEN      = 3'd2,
		CFG_SENSOR_HEIGHT  = 3'd3,
		CFG_ENVELOPE_TAN   = 3'd4,
		CFG_POINT_TRIGGER  = 3'd5,
		CFG_LIDAR_PERSIST  = 3'd6,
		CFG_CAMERA_PERSIST = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_POS  = 2'd1,
		TURN_NEG  = 2'd2
	} turn_t;

	typedef enum logic [1:0] {
		CAM_NONE  = 2'd0,
		CAM_LEFT  = 2'd1,
		CAM_RIGHT = 2'd2,
		CAM_OTHER = 2'd3
	} cam_t;

	typedef struct packed {
		logic [LEN_W-1:0]  half_width_mm;
		logic [LEN_W-1:0]  slowdown_length_mm;
		logic [LEN_W-1:0]  avoid_length_mm;
		logic [LEN_W-1:0]  sensor_height_mm;
		logic [TAN_W-1:0]  envelope_tan_q8;
		logic [TRIG_W-1:0] point_trigger;
		logic [PCFG_W-1:0] lidar_persist;
		logic [PCFG_W-1:0] camera_persist;
	} cop_cfg_t;

	// Classified point, one per transaction, handed to the frame tracker
	typedef struct packed {
		logic slow_hit;
		logic avoid_hit;
		logic right_side;
		logic frame_end;
		cam_t camera_code;
	} cop_hit_t;

	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [PERSIST_W-1:0] persist_t;

	function automatic count_t sat_count(input count_t v);
		return (v == COUNT_W'(POINT_COUNT_MAX)) ? v : v + COUNT_W'(1);
	endfunction

	function automatic persist_t sat_persist(input persist_t v);
		return (v == PERSIST_W'(PERSIST_MAX)) ? v : v + PERSIST_W'(1);
	endfunction

	function automatic logic [HITS_W-1:0] cap_hits(input count_t v);
		logic [31:0] wide;
		wide = 32'(v);
		return (wide > 32'hFFFF) ? {HITS_W{1'b1}} : wide[HITS_W-1:0];
	endfunction

endpackage

// ===== sv/cop_cfg_regs.sv =====
module cop_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [cop_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cop_pkg::CFG_DATA_W-1:0]      cfg_data,
	output cop_pkg::cop_cfg_t                   cfg
);

	cop_pkg::cop_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width_mm      <= cop_pkg::HALF_WIDTH_RST;
			cfg_q.slowdown_length_mm <= cop_pkg::SLOWDOWN_LEN_RST;
			cfg_q.avoid_length_mm    <= cop_pkg::AVOID_LEN_RST;
			cfg_q.sensor_height_mm   <= cop_pkg::SENSOR_HEIGHT_RST;
			cfg_q.envelope_tan_q8    <= cop_pkg::ENVELOPE_TAN_RST;
			cfg_q.point_trigger      <= cop_pkg::POINT_TRIGGER_RST;
			cfg_q.lidar_persist      <= cop_pkg::LIDAR_PERSIST_RST;
			cfg_q.camera_persist     <= cop_pkg::CAMERA_PERSIST_RST;
		end else if (cfg_en) begin
			unique case (cop_pkg::cfg_reg_t'(cfg_index))
				cop_pkg::CFG_HALF_WIDTH: begin
					cfg_q.half_width_mm <= cfg_data[cop_pkg::LEN_W-1:0];
				end
				cop_pkg::CFG_SLOWDOWN_LEN: begin
					cfg_q.slowdown_length_mm <= cfg_data[cop_pkg::LEN_W-1:0];
				end
				cop_pkg::CFG_AVOID_LEN: begin
					cfg_q.avoid_length_mm <= cfg_data[cop_pkg::LEN_W-1:0];
				end
				cop_pkg::CFG_SENSOR_HEIGHT: begin
					cfg_q.sensor_height_mm <= cfg_data[cop_pkg::LEN_W-1:0];
				end
				cop_pkg::CFG_ENVELOPE_TAN: begin
					cfg_q.envelope_tan_q8 <= cfg_data[cop_pkg::TAN_W-1:0];
				end
				cop_pkg::CFG_POINT_TRIGGER: begin
					cfg_q.point_trigger <= cfg_data[cop_pkg::TRIG_W-1:0];
				end
				cop_pkg::CFG_LIDAR_PERSIST: begin
					cfg_q.lidar_persist <= cfg_data[cop_pkg::PCFG_W-1:0];
				end
				cop_pkg::CFG_CAMERA_PERSIST: begin
					cfg_q.camera_persist <= cfg_data[cop_pkg::PCFG_W-1:0];
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/cop_point_classify.sv =====
module cop_point_classify (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cop_pkg::cop_cfg_t                   cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                point_valid,
	input  logic signed [cop_pkg::COORD_W-1:0]  x_mm,
	input  logic signed [cop_pkg::COORD_W-1:0]  y_mm,
	input  logic signed [cop_pkg::COORD_W-1:0]  z_mm,
	input  logic                                frame_end,
	input  logic [1:0]                          camera_code,
	output logic                                hit_valid,
	output cop_pkg::cop_hit_t                   hit,
	input  logic                                hit_take
);

	logic                               valid_s1;
	logic                               pv_s1;
	logic signed [cop_pkg::COORD_W-1:0] x_s1;
	logic signed [cop_pkg::COORD_W-1:0] y_s1;
	logic signed [cop_pkg::COORD_W-1:0] z_s1;
	logic                               fe_s1;
	logic [1:0]                         cam_s1;

	logic              valid_s2;
	cop_pkg::cop_hit_t hit_s2;

	logic advance_s1;

	logic signed [17:0] z_w;
	logic signed [17:0] y_w;
	logic signed [17:0] h_w;
	logic signed [17:0] hw_w;
	logic signed [17:0] diff;
	logic [16:0]        abs_dz;
	logic [31:0]        lhs;
	logic [30:0]        rhs;
	logic               in_band;
	logic               in_width;
	logic               ahead;
	logic               outside_env;
	logic               in_corridor;
	cop_pkg::cop_hit_t  hit_d;

	assign advance_s1 = !valid_s2 || hit_take;
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pv_s1  <= point_valid;
			x_s1   <= x_mm;
			y_s1   <= y_mm;
			z_s1   <= z_mm;
			fe_s1  <= frame_end;
			cam_s1 <= camera_code;
		end
		if (advance_s1 && valid_s1) begin
			hit_s2 <= hit_d;
		end
	end

	always_comb begin
		z_w  = {{2{z_s1[15]}}, z_s1};
		y_w  = {{2{y_s1[15]}}, y_s1};
		h_w  = {3'b000, cfg.sensor_height_mm};
		hw_w = {3'b000, cfg.half_width_mm};

		in_band  = (z_w < 18'sd1500) && (z_w > h_w - 18'(cop_pkg::HEIGHT_BAND_MM));
		in_width = (y_w < hw_w) && (y_w > -hw_w);
		ahead    = !x_s1[15] && (x_s1 != '0);

		// |height - z| * 256 against x * tangent; only positive x counts, through ahead
		diff   = h_w - z_w;
		abs_dz = diff[17] ? 17'(-diff) : diff[16:0];
		lhs    = {7'd0, abs_dz, 8'd0};
		rhs    = 31'(x_s1[14:0]) * 31'(cfg.envelope_tan_q8);
		outside_env = lhs > {1'b0, rhs};

		in_corridor = pv_s1 && in_band && in_width && ahead && outside_env;

		hit_d.slow_hit    = in_corridor && (x_s1[14:0] < cfg.slowdown_length_mm);
		hit_d.avoid_hit   = in_corridor && (x_s1[14:0] < cfg.avoid_length_mm);
		// centre line counts as left
		hit_d.right_side  = !y_s1[15] && (y_s1 != '0);
		hit_d.frame_end   = fe_s1;
		hit_d.camera_code = cop_pkg::cam_t'(cam_s1);
	end

	assign hit_valid = valid_s2;
	assign hit       = hit_s2;

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !hit_take |=> valid_s2 && $stable(hit_s2))
		else $error("classified point changed while stalled");

	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transaction not held in first stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_ready |=> valid_s1 && $stable(x_s1) && $stable(fe_s1))
		else $error("first stage lost a stalled point");

endmodule

// ===== sv/cop_frame_tracker.sv =====
module cop_frame_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cop_pkg::cop_cfg_t             cfg,
	input  logic                          hit_valid,
	input  cop_pkg::cop_hit_t             hit,
	output logic                          hit_take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          collision,
	output logic                          slow_down,
	output logic [1:0]                    turn_code,
	output logic                          drive_short,
	output logic [cop_pkg::HITS_W-1:0]    left_hits,
	output logic [cop_pkg::HITS_W-1:0]    right_hits
);

	cop_pkg::count_t   slow_q, avoid_q, left_q, right_q;
	cop_pkg::persist_t slow_persist_q, avoid_persist_q, cam_persist_q;
	logic              slow_flag_q;
	cop_pkg::turn_t    turn_q;
	logic              drive_q;
	logic              out_valid_q;
	logic              coll_q;
	logic [cop_pkg::HITS_W-1:0] left_out_q, right_out_q;

	logic              consume;
	logic              close_frame;
	cop_pkg::count_t   slow_n, avoid_n, left_n, right_n;
	cop_pkg::persist_t sp_n, ap_n, cp_n;
	logic              cam_reach;
	logic              coll_n;
	logic              slow_flag_n;
	cop_pkg::turn_t    turn_n;
	logic              drive_n;

	// a frame end must wait for the result register to free up
	assign hit_take    = !(hit.frame_end && out_valid_q && !out_ready);
	assign consume     = hit_valid && hit_take;
	assign close_frame = consume && hit.frame_end;

	always_comb begin
		slow_n  = hit.slow_hit ? cop_pkg::sat_count(slow_q) : slow_q;
		avoid_n = hit.avoid_hit ? cop_pkg::sat_count(avoid_q) : avoid_q;
		left_n  = (hit.avoid_hit && !hit.right_side) ? cop_pkg::sat_count(left_q) : left_q;
		right_n = (hit.avoid_hit && hit.right_side) ? cop_pkg::sat_count(right_q) : right_q;

		sp_n = (32'(slow_n) > 32'(cfg.point_trigger)) ?
			cop_pkg::sat_persist(slow_persist_q) : '0;
		ap_n = (32'(avoid_n) > 32'(cfg.point_trigger)) ?
			cop_pkg::sat_persist(avoid_persist_q) : '0;
		cp_n = (hit.camera_code != cop_pkg::CAM_NONE) ?
			cop_pkg::sat_persist(cam_persist_q) : '0;

		cam_reach = 32'(cp_n) >= 32'(cfg.camera_persist);
		coll_n    = (32'(ap_n) >= 32'(cfg.lidar_persist)) || cam_reach;

		slow_flag_n = slow_flag_q;
		turn_n      = turn_q;
		drive_n     = drive_q;

		priority if (coll_n) begin
			if (cam_reach) begin
				unique case (hit.camera_code)
					cop_pkg::CAM_LEFT:  turn_n = cop_pkg::TURN_POS;
					cop_pkg::CAM_RIGHT: turn_n = cop_pkg::TURN_NEG;
					cop_pkg::CAM_NONE,
					cop_pkg::CAM_OTHER: turn_n = turn_q;
				endcase
			end else begin
				turn_n = (left_n > right_n) ? cop_pkg::TURN_POS : cop_pkg::TURN_NEG;
			end
			drive_n = 1'b1;
			sp_n    = '0;
			ap_n    = '0;
			cp_n    = '0;
		end else if (32'(sp_n) >= 32'(cfg.lidar_persist)) begin
			slow_flag_n = 1'b1;
			turn_n      = cop_pkg::TURN_NONE;
			drive_n     = 1'b0;
		end else begin
			slow_flag_n = 1'b0;
			turn_n      = cop_pkg::TURN_NONE;
			drive_n     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q          <= '0;
			avoid_q         <= '0;
			left_q          <= '0;
			right_q         <= '0;
			slow_persist_q  <= '0;
			avoid_persist_q <= '0;
			cam_persist_q   <= '0;
			slow_flag_q     <= 1'b0;
			turn_q          <= cop_pkg::TURN_NONE;
			drive_q         <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (close_frame) begin
				slow_q          <= '0;
				avoid_q         <= '0;
				left_q          <= '0;
				right_q         <= '0;
				slow_persist_q  <= sp_n;
				avoid_persist_q <= ap_n;
				cam_persist_q   <= cp_n;
				slow_flag_q     <= slow_flag_n;
				turn_q          <= turn_n;
				drive_q         <= drive_n;
			end else if (consume) begin
				slow_q  <= slow_n;
				avoid_q <= avoid_n;
				left_q  <= left_n;
				right_q <= right_n;
			end

			if (close_frame) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close_frame) begin
			coll_q      <= coll_n;
			left_out_q  <= cop_pkg::cap_hits(left_n);
			right_out_q <= cop_pkg::cap_hits(right_n);
		end
	end

	assign out_valid   = out_valid_q;
	assign collision   = coll_q;
	assign slow_down   = slow_flag_q;
	assign turn_code   = turn_q;
	assign drive_short = drive_q;
	assign left_hits   = left_out_q;
	assign right_hits  = right_out_q;

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		close_frame |=> slow_q == '0 && avoid_q == '0 && left_q == '0 && right_q == '0)
		else $error("frame counts not cleared at frame end");

	a_coll_persist: assert property (@(posedge clk) disable iff (!arst_n)
		close_frame && coll_n |=> slow_persist_q == '0 && avoid_persist_q == '0
			&& cam_persist_q == '0)
		else $error("persistence counters survived a collision frame");

	a_coll_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && coll_q |-> drive_q)
		else $error("collision result without short drive");

	a_quiet_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !coll_q |-> turn_q == cop_pkg::TURN_NONE && !drive_q)
		else $error("turn or drive set without collision");

endmodule

// ===== sv/corridor_obstacle_point_counter.sv =====
// Path: a frame_end transaction passes the input register, the classification register
// (fed by the envelope multiply) and the result register, which raises out_valid.
// Throughput: one point per cycle unless stalled; the frame counters update once per point taken.
// Input stalls only while a frame end waits on a result that has not been taken.
// Reset (arst_n low, asynchronous): counters, slow-down and drive flags, turn code and handshakes
// clear, configuration registers return to their defaults; collision and hit-count outputs are not reset.
module corridor_obstacle_point_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [cop_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cop_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                point_valid,
	input  logic signed [cop_pkg::COORD_W-1:0]  x_mm,
	input  logic signed [cop_pkg::COORD_W-1:0]  y_mm,
	input  logic signed [cop_pkg::COORD_W-1:0]  z_mm,
	input  logic                                frame_end,
	input  logic [1:0]                          camera_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                collision,
	output logic                                slow_down,
	output logic [1:0]                          turn_code,
	output logic                                drive_short,
	output logic [cop_pkg::HITS_W-1:0]          left_hits,
	output logic [cop_pkg::HITS_W-1:0]          right_hits
);

	cop_pkg::cop_cfg_t cfg;
	cop_pkg::cop_hit_t hit;
	logic              hit_valid;
	logic              hit_take;

	cop_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cop_point_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_valid (point_valid),
		.x_mm        (x_mm),
		.y_mm        (y_mm),
		.z_mm        (z_mm),
		.frame_end   (frame_end),
		.camera_code (camera_code),
		.hit_valid   (hit_valid),
		.hit         (hit),
		.hit_take    (hit_take)
	);

	cop_frame_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.hit_valid   (hit_valid),
		.hit         (hit),
		.hit_take    (hit_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.collision   (collision),
		.slow_down   (slow_down),
		.turn_code   (turn_code),
		.drive_short (drive_short),
		.left_hits   (left_hits),
		.right_hits  (right_hits)
	);

endmodule

// ===== tb/tb_corridor_obstacle_point_counter.sv =====
`timescale 1ns / 100ps

module tb_corridor_obstacle_point_counter;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 125;
	localparam int SAT_FRAMES    = 300;

	localparam cop_pkg::cop_cfg_t RESET_CFG = '{
		half_width_mm:      cop_pkg::HALF_WIDTH_RST,
		slowdown_length_mm: cop_pkg::SLOWDOWN_LEN_RST,
		avoid_length_mm:    cop_pkg::AVOID_LEN_RST,
		sensor_height_mm:   cop_pkg::SENSOR_HEIGHT_RST,
		envelope_tan_q8:    cop_pkg::ENVELOPE_TAN_RST,
		point_trigger:      cop_pkg::POINT_TRIGGER_RST,
		lidar_persist:      cop_pkg::LIDAR_PERSIST_RST,
		camera_persist:     cop_pkg::CAMERA_PERSIST_RST
	};

	typedef struct {
		bit                                 pv;
		logic signed [cop_pkg::COORD_W-1:0] x;
		logic signed [cop_pkg::COORD_W-1:0] y;
		logic signed [cop_pkg::COORD_W-1:0] z;
		bit                                 fe;
		cop_pkg::cam_t                      cam;
	} lidar_item_t;

	typedef struct packed {
		logic                       collision;
		logic                       slow_down;
		cop_pkg::turn_t             turn;
		logic                       drive_short;
		logic [cop_pkg::HITS_W-1:0] left_hits;
		logic [cop_pkg::HITS_W-1:0] right_hits;
	} obstacle_report_t;

	class frame_report_predictor;
		cop_pkg::cop_cfg_t cfg;
		int unsigned       slow_hits, avoid_hits, left_count, right_count;
		int unsigned       slow_persist, avoid_persist, cam_persist;
		bit                slow_flag, drive_state;
		cop_pkg::turn_t    turn_state;
		obstacle_report_t  pending[$];
		int                errors;

		function new();
			cfg = RESET_CFG;
			turn_state = cop_pkg::TURN_NONE;
		endfunction

		function int unsigned bump(int unsigned v, int unsigned lim);
			return (v < lim) ? v + 1 : lim;
		endfunction

		function logic [cop_pkg::HITS_W-1:0] cap(int unsigned v);
			return (v > 32'hFFFF) ? {cop_pkg::HITS_W{1'b1}} : v[cop_pkg::HITS_W-1:0];
		endfunction

		function void note_item(lidar_item_t it);
			longint hw, h, xs, ys, zs, d;
			obstacle_report_t r;
			hw = longint'(cfg.half_width_mm);
			h  = longint'(cfg.sensor_height_mm);
			xs = longint'(it.x);
			ys = longint'(it.y);
			zs = longint'(it.z);
			d  = (h > zs) ? h - zs : zs - h;
			if (it.pv && zs < cop_pkg::HEIGHT_BAND_MM && zs > h - cop_pkg::HEIGHT_BAND_MM
					&& ys < hw && ys > -hw
					&& xs > 0 && d * 256 > xs * longint'(cfg.envelope_tan_q8)) begin
				if (xs < longint'(cfg.slowdown_length_mm))
					slow_hits = bump(slow_hits, cop_pkg::POINT_COUNT_MAX);
				if (xs < longint'(cfg.avoid_length_mm)) begin
					avoid_hits = bump(avoid_hits, cop_pkg::POINT_COUNT_MAX);
					// centre line goes to the left
					if (ys > 0)
						right_count = bump(right_count, cop_pkg::POINT_COUNT_MAX);
					else
						left_count = bump(left_count, cop_pkg::POINT_COUNT_MAX);
				end
			end
			if (!it.fe)
				return;

			slow_persist  = (slow_hits > cfg.point_trigger) ?
				bump(slow_persist, cop_pkg::PERSIST_MAX) : 0;
			avoid_persist = (avoid_hits > cfg.point_trigger) ?
				bump(avoid_persist, cop_pkg::PERSIST_MAX) : 0;
			cam_persist   = (it.cam != cop_pkg::CAM_NONE) ?
				bump(cam_persist, cop_pkg::PERSIST_MAX) : 0;

			if (avoid_persist >= cfg.lidar_persist || cam_persist >= cfg.camera_persist) begin
				r.collision = 1'b1;
				if (cam_persist >= cfg.camera_persist) begin
					if (it.cam == cop_pkg::CAM_LEFT)
						turn_state = cop_pkg::TURN_POS;
					else if (it.cam == cop_pkg::CAM_RIGHT)
						turn_state = cop_pkg::TURN_NEG;
				end else begin
					turn_state = (left_count > right_count) ? cop_pkg::TURN_POS : cop_pkg::TURN_NEG;
				end
				drive_state   = 1'b1;
				slow_persist  = 0;
				avoid_persist = 0;
				cam_persist   = 0;
			end else begin
				r.collision = 1'b0;
				slow_flag   = (slow_persist >= cfg.lidar_persist);
				turn_state  = cop_pkg::TURN_NONE;
				drive_state = 1'b0;
			end

			r.slow_down   = slow_flag;
			r.turn        = turn_state;
			r.drive_short = drive_state;
			r.left_hits   = cap(left_count);
			r.right_hits  = cap(right_count);
			pending = {pending, r};

			slow_hits   = 0;
			avoid_hits  = 0;
			left_count  = 0;
			right_count = 0;
		endfunction

		function void check_report(obstacle_report_t got);
			obstacle_report_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected report coll=%0d slow=%0d turn=%0d drive=%0d left=%0d right=%0d",
					$time, got.collision, got.slow_down, got.turn, got.drive_short,
					got.left_hits, got.right_hits);
				return;
			end
			want = pending.pop_front();
			if (got.collision !== want.collision || got.slow_down !== want.slow_down
					|| got.turn !== want.turn || got.drive_short !== want.drive_short
					|| got.left_hits !== want.left_hits || got.right_hits !== want.right_hits) begin
				errors++;
				$display("%0t: report mismatch expected coll=%0d slow=%0d turn=%0d drive=%0d left=%0d right=%0d",
					$time, want.collision, want.slow_down, want.turn, want.drive_short,
					want.left_hits, want.right_hits);
				$display("%0t:                 actual   coll=%0d slow=%0d turn=%0d drive=%0d left=%0d right=%0d",
					$time, got.collision, got.slow_down, got.turn, got.drive_short,
					got.left_hits, got.right_hits);
			end
		endfunction
	endclass

	logic                               clk         = 1'b0;
	logic                               arst_n      = 1'b0;
	logic                               cfg_en      = 1'b0;
	logic [cop_pkg::CFG_INDEX_W-1:0]    cfg_index   = cop_pkg::CFG_HALF_WIDTH;
	logic [cop_pkg::CFG_DATA_W-1:0]     cfg_data    = '0;
	logic                               in_valid    = 1'b0;
	logic                               in_ready;
	logic                               point_valid = 1'b0;
	logic signed [cop_pkg::COORD_W-1:0] x_mm        = '0;
	logic signed [cop_pkg::COORD_W-1:0] y_mm        = '0;
	logic signed [cop_pkg::COORD_W-1:0] z_mm        = '0;
	logic                               frame_end   = 1'b0;
	logic [1:0]                         camera_code = cop_pkg::CAM_NONE;
	logic                               out_valid;
	logic                               out_ready   = 1'b0;
	logic                               collision;
	logic                               slow_down;
	logic [1:0]                         turn_code;
	logic                               drive_short;
	logic [cop_pkg::HITS_W-1:0]         left_hits;
	logic [cop_pkg::HITS_W-1:0]         right_hits;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	frame_report_predictor frame_model = new();

	corridor_obstacle_point_counter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_en      (cfg_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_valid (point_valid),
		.x_mm        (x_mm),
		.y_mm        (y_mm),
		.z_mm        (z_mm),
		.frame_end   (frame_end),
		.camera_code (camera_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.collision   (collision),
		.slow_down   (slow_down),
		.turn_code   (turn_code),
		.drive_short (drive_short),
		.left_hits   (left_hits),
		.right_hits  (right_hits)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reports outstanding", $time, frame_model.pending.size());
			$display("** corridor_obstacle_point_counter: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : report_monitor
		obstacle_report_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.collision   = collision;
			seen.slow_down   = slow_down;
			seen.turn        = cop_pkg::turn_t'(turn_code);
			seen.drive_short = drive_short;
			seen.left_hits   = left_hits;
			seen.right_hits  = right_hits;
			frame_model.check_report(seen);
		end
	end

	task automatic set_idle(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
			default: begin send_idle_pct = 28; recv_stall_pct = 28; end
		endcase
	endtask

	task automatic write_reg(input cop_pkg::cfg_reg_t idx,
			input logic [cop_pkg::CFG_DATA_W-1:0] val);
		cfg_en    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Unused upper data bits carry junk when asked, the block must ignore them
	task automatic program_corridor(input cop_pkg::cop_cfg_t c, input bit junk);
		write_reg(cop_pkg::CFG_HALF_WIDTH,     {junk & 1'($urandom), c.half_width_mm});
		write_reg(cop_pkg::CFG_SLOWDOWN_LEN,   {junk & 1'($urandom), c.slowdown_length_mm});
		write_reg(cop_pkg::CFG_AVOID_LEN,      {junk & 1'($urandom), c.avoid_length_mm});
		write_reg(cop_pkg::CFG_SENSOR_HEIGHT,  {junk & 1'($urandom), c.sensor_height_mm});
		write_reg(cop_pkg::CFG_ENVELOPE_TAN,   c.envelope_tan_q8);
		write_reg(cop_pkg::CFG_POINT_TRIGGER,  c.point_trigger);
		write_reg(cop_pkg::CFG_LIDAR_PERSIST,  {junk ? 8'($urandom) : 8'd0, c.lidar_persist});
		write_reg(cop_pkg::CFG_CAMERA_PERSIST, {junk ? 8'($urandom) : 8'd0, c.camera_persist});
		cfg_en <= 1'b0;
		frame_model.cfg = c;
	endtask

	task automatic send_item(input lidar_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		point_valid <= it.pv;
		x_mm        <= it.x;
		y_mm        <= it.y;
		z_mm        <= it.z;
		frame_end   <= it.fe;
		camera_code <= it.cam;
		do @(posedge clk); while (!in_ready);
		frame_model.note_item(it);
		@(negedge clk);
	endtask

	// Drain every report, then give the pipeline time to swallow trailing points
	task automatic settle();
		in_valid <= 1'b0;
		while (frame_model.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic lidar_item_t point_item(int pv, int x, int y, int z, int fe,
			cop_pkg::cam_t cam);
		lidar_item_t it;
		it.pv  = (pv != 0);
		it.x   = 16'(x);
		it.y   = 16'(y);
		it.z   = 16'(z);
		it.fe  = (fe != 0);
		it.cam = cam;
		return it;
	endfunction

	function automatic cop_pkg::cam_t pick_cam();
		return ($urandom_range(0, 2) != 0) ? cop_pkg::cam_t'($urandom_range(1, 3)) : cop_pkg::CAM_NONE;
	endfunction

	function automatic lidar_item_t noise_item();
		return point_item($urandom_range(0, 1), $urandom, $urandom, $urandom,
			$urandom_range(0, 1), cop_pkg::cam_t'($urandom_range(0, 3)));
	endfunction

	// Points on or next to each classification boundary
	function automatic lidar_item_t edge_item();
		int hw, h, av, sl, x, y, z;
		hw = int'(frame_model.cfg.half_width_mm);
		h  = int'(frame_model.cfg.sensor_height_mm);
		av = int'(frame_model.cfg.avoid_length_mm);
		sl = int'(frame_model.cfg.slowdown_length_mm);
		case ($urandom_range(0, 8))
			0: x = 0;
			1: x = 1;
			2: x = -1;
			3: x = av;
			4: x = av - 1;
			5: x = sl;
			6: x = sl - 1;
			7: x = 32767;
			default: x = -32768;
		endcase
		case ($urandom_range(0, 8))
			0: y = 0;
			1: y = hw;
			2: y = -hw;
			3: y = hw - 1;
			4: y = 1 - hw;
			5: y = 1;
			6: y = -1;
			7: y = 32767;
			default: y = -32768;
		endcase
		case ($urandom_range(0, 8))
			0: z = cop_pkg::HEIGHT_BAND_MM;
			1: z = cop_pkg::HEIGHT_BAND_MM - 1;
			2: z = h - cop_pkg::HEIGHT_BAND_MM;
			3: z = h - cop_pkg::HEIGHT_BAND_MM + 1;
			4: z = h;
			5: z = h + 1;
			6: z = h - 1;
			7: z = 32767;
			default: z = -32768;
		endcase
		return point_item(1, x, y, z, 0, cop_pkg::CAM_NONE);
	endfunction

	// Points placed inside the band and corridor, mostly outside the envelope
	function automatic lidar_item_t aimed_item();
		int hw, h, tanv, lo, hi, x, y, z, d, xmax, xcap;
		hw   = int'(frame_model.cfg.half_width_mm);
		h    = int'(frame_model.cfg.sensor_height_mm);
		tanv = int'(frame_model.cfg.envelope_tan_q8);
		lo   = h - cop_pkg::HEIGHT_BAND_MM + 1;
		hi   = cop_pkg::HEIGHT_BAND_MM - 1;
		if (lo <= hi)
			z = lo + int'($urandom_range(0, hi - lo));
		else
			z = $urandom_range(0, 3000) - 1500;
		d = (h > z) ? h - z : z - h;
		if (tanv == 0)
			xmax = 32767;
		else
			xmax = int'((longint'(d) * 256 - 1) / tanv);
		xcap = int'(frame_model.cfg.slowdown_length_mm);
		if (int'(frame_model.cfg.avoid_length_mm) > xcap)
			xcap = int'(frame_model.cfg.avoid_length_mm);
		xcap = (xcap + 200 > 32767) ? 32767 : xcap + 200;
		if (xmax > xcap)
			xmax = xcap;
		if (xmax < 1)
			xmax = 1;
		x = $urandom_range(1, xmax);
		if (hw > 0)
			y = int'($urandom_range(0, 2 * hw - 2)) - (hw - 1);
		else
			y = int'($urandom_range(0, 200)) - 100;
		return point_item(1, x, y, z, 0, cop_pkg::CAM_NONE);
	endfunction

	function automatic lidar_item_t frame_point();
		lidar_item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 12)
			return noise_item();
		it = (sel < 27) ? edge_item() : aimed_item();
		it.pv  = ($urandom_range(0, 9) != 0);
		it.cam = cop_pkg::cam_t'($urandom_range(0, 3));
		if (!it.pv) begin
			it.x = 16'($urandom);
			it.y = 16'($urandom);
			it.z = 16'($urandom);
		end
		return it;
	endfunction

	task automatic run_frames(input int target);
		int sent, len;
		lidar_item_t it;
		sent = 0;
		while (sent < target) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			for (int k = 0; k < len; k++) begin
				it = frame_point();
				send_item(it);
				sent++;
			end
			it     = frame_point();
			it.fe  = 1'b1;
			it.cam = pick_cam();
			send_item(it);
			sent++;
		end
	endtask

	task automatic run_directed();
		send_item(point_item(1, 100, 0, 700, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 1, 700, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 150, -3, 700, 1, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 5, 700, 1, cop_pkg::CAM_NONE));
		send_item(point_item(1, 4000, 0, 100, 1, cop_pkg::CAM_NONE));
		send_item(point_item(0, 100, 0, 700, 0, cop_pkg::CAM_LEFT));
		send_item(point_item(0, 0, 0, 0, 1, cop_pkg::CAM_LEFT));
		send_item(point_item(0, 0, 0, 0, 1, cop_pkg::CAM_RIGHT));
		send_item(point_item(0, 0, 0, 0, 1, cop_pkg::CAM_OTHER));
		send_item(point_item(0, 0, 0, 0, 1, cop_pkg::CAM_OTHER));
		send_item(point_item(0, 0, 0, 0, 1, cop_pkg::CAM_LEFT));
		send_item(point_item(0, 0, 0, 0, 1, cop_pkg::CAM_LEFT));
		send_item(point_item(1, 3500, 0, 300, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 3499, -999, 300, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 1000, 700, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 999, 1499, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 0, 1500, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 0, -300, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 100, 0, -299, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 0, 0, 700, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, -32768, -32768, -32768, 0, cop_pkg::CAM_NONE));
		send_item(point_item(1, 32767, 32767, 32767, 1, cop_pkg::CAM_NONE));
		send_item(point_item(0, -1, -1, -1, 1, cop_pkg::CAM_NONE));
	endtask

	function automatic cop_pkg::cop_cfg_t phase_cfg(input int phase);
		cop_pkg::cop_cfg_t c;
		case (phase)
			0: c = RESET_CFG;
			1: c = '{15'd1000, 15'd6000, 15'd3500, 15'd1200, 16'd256, 16'd3, 8'd2, 8'd3};
			2: c = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
			3: c = '0;
			4: c = '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0, 16'd0, 16'd0, 8'd1, 8'hFF};
			default: begin
				c.half_width_mm      = 15'($urandom_range(200, 3000));
				c.slowdown_length_mm = 15'($urandom_range(0, 8000));
				c.avoid_length_mm    = 15'($urandom_range(0, 5000));
				c.sensor_height_mm   = 15'($urandom_range(0, 2900));
				c.envelope_tan_q8    = 16'($urandom_range(0, 1024));
				c.point_trigger      = 16'($urandom_range(0, 6));
				c.lidar_persist      = 8'($urandom_range(0, 3));
				c.camera_persist     = 8'($urandom_range(0, 4));
			end
		endcase
		return c;
	endfunction

	initial begin
		cop_pkg::cop_cfg_t c;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		c = RESET_CFG;
		c.envelope_tan_q8 = 16'd64;
		c.point_trigger   = 16'd0;
		c.lidar_persist   = 8'd1;
		c.camera_persist  = 8'd2;
		program_corridor(c, 1'b0);
		run_directed();
		settle();

		for (int p = 0; p < 8; p++) begin
			program_corridor(phase_cfg(p), p >= 5);
			set_idle(p % 4);
			run_frames(PHASE_ITEMS);
			settle();
		end

		// One slow-only point per frame pushes the slowdown persistence counter into saturation
		c = '{15'd1000, 15'd6000, 15'd0, 15'd1200, 16'd64, 16'd0, 8'hFF, 8'hFF};
		program_corridor(c, 1'b0);
		set_idle(3);
		for (int f = 0; f < SAT_FRAMES; f++)
			send_item(point_item(1, 1000, int'($urandom_range(0, 1998)) - 999, 100, 1,
				cop_pkg::CAM_NONE));
		settle();

		if (frame_model.errors == 0 && frame_model.pending.size() == 0) begin
			$display("** corridor_obstacle_point_counter: PASSED **");
		end else begin
			$display("%0t: %0d mismatches, %0d reports missing", $time, frame_model.errors,
				frame_model.pending.size());
			$display("** corridor_obstacle_point_counter: FAILED **");
		end
		$finish;
	end

endmodule
